@@ design/sru_pkg.sv @@
// Package for the symmetric rank-1 update block: codes, constants and the sequencer states.
package sru_pkg;

	// Default order of the largest matrix the block holds.
	localparam int MAX_ORDER_DEF = 16;

	// Operation codes carried in the op field of a request.
	localparam logic [1:0] OP_LOAD_X = 2'd0;
	localparam logic [1:0] OP_LOAD_M = 2'd1;
	localparam logic [1:0] OP_RUN    = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MATRIX_SIZE = 2'd0;
	localparam logic [1:0] CFG_FILL_UPPER  = 2'd1;
	localparam logic [1:0] CFG_ALPHA       = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [4:0]        MATRIX_SIZE_RST = 5'd16;
	localparam logic              FILL_UPPER_RST  = 1'b1;
	localparam logic signed [31:0] ALPHA_RST      = 32'sd0;

	// Saturation limits of a stored entry.
	localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

	// Update sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COL_RD,
		ST_COL_MUL,
		ST_COL_T,
		ST_ENT_RD,
		ST_ENT_MHI,
		ST_ENT_MLO,
		ST_ENT_SUM,
		ST_ENT_WR,
		ST_DONE
	} state_t;

endpackage

@@ design/symmetric_rank1_update.sv @@
// Symmetric rank-1 update engine: x and matrix memories, update sequencer and result register.
// Load and read requests: one per cycle while idle and not stalled; a result passes the read
// stage, then the result register. Per column a run reads x[j] and, if nonzero, forms t; per
// triangle entry it reads, multiplies twice, sums and writes, on the shared 32x32 multiplier
// and the single matrix port pair; zero alpha or order goes to done. A run holds in_ready low.
// Reset clears the control state and sets matrix_size 16, fill_upper 1, alpha 0; the
// memories are not cleared.
module symmetric_rank1_update #(
	parameter int MAX_ORDER = sru_pkg::MAX_ORDER_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	// Request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [3:0]         row,
	input  logic [3:0]         col,
	input  logic signed [31:0] value,
	// Result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] read_value,
	output logic               run_done
);

	localparam int IDXW = $clog2(MAX_ORDER);
	localparam int MAW  = $clog2(MAX_ORDER * MAX_ORDER);
	localparam int CW   = $clog2(MAX_ORDER + 1);

	// Configuration registers
	logic [4:0]         matrix_size_q;
	logic               fill_upper_q;
	logic signed [31:0] alpha_q;

	// Sequencer and counters
	sru_pkg::state_t state_q, state_d;
	logic [IDXW-1:0] j_q, i_q;
	logic            j_clr, j_inc, i_init, i_inc;

	// Datapath registers
	logic signed [63:0] prod_q, ph_q, p_q;
	logic signed [47:0] t_q;
	logic               mul_en, t_en, ph_en, p_en;
	logic signed [31:0] mul_a, mul_b;

	// Read pipeline stage and result register
	logic               valid_s1, read_s1;
	logic               out_valid_q, run_done_q;
	logic signed [31:0] read_value_q;
	logic               adv, accept, s1_load, out_from_s1, out_from_run;

	// Memory ports
	logic              x_we, x_re, m_we, m_re;
	logic [IDXW-1:0]   x_waddr, x_raddr;
	logic [MAW-1:0]    m_waddr, m_raddr;
	logic [31:0]       x_wdata, m_wdata, x_rdata, m_rdata;

	// Decoded request and derived values
	logic               row_ok, col_ok;
	logic [CW-1:0]      n_w;
	logic               last_col, last_ent;
	logic [79:0]        p_full;
	logic signed [64:0] acc_w;
	logic signed [31:0] sat_w;

	function automatic logic [MAW-1:0] m_addr(input logic [IDXW-1:0] r,
			input logic [IDXW-1:0] c);
		m_addr = MAW'(MAW'(r) * MAW'(MAX_ORDER) + MAW'(c));
	endfunction

	sru_ram #(.WIDTH(32), .DEPTH(MAX_ORDER)) u_x_ram (
		.clk   (clk),
		.we    (x_we),
		.waddr (x_waddr),
		.wdata (x_wdata),
		.re    (x_re),
		.raddr (x_raddr),
		.rdata (x_rdata)
	);

	sru_ram #(.WIDTH(32), .DEPTH(MAX_ORDER * MAX_ORDER)) u_m_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.re    (m_re),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	// Effective order and position flags.
	assign n_w      = (32'(matrix_size_q) > 32'(MAX_ORDER)) ?
	                  CW'(MAX_ORDER) : CW'(matrix_size_q);
	assign last_col = (CW'(j_q) + CW'(1)) == n_w;
	assign last_ent = fill_upper_q ? (i_q == j_q) : ((CW'(i_q) + CW'(1)) == n_w);
	assign row_ok   = 32'(row) < 32'(MAX_ORDER);
	assign col_ok   = 32'(col) < 32'(MAX_ORDER);

	// Handshakes: the read stage moves on when the result register is free or draining.
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = (state_q == sru_pkg::ST_IDLE) && (!valid_s1 || adv);
	assign accept   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Recombine the two partial products of t * x[i].
	assign p_full = (({{16{ph_q[63]}}, ph_q}) << 24) + {{16{prod_q[63]}}, prod_q};

	// Add the scaled product to the entry and saturate to 32 bits.
	assign acc_w = {{33{m_rdata[31]}}, m_rdata} + {p_q[63], p_q};
	always_comb begin
		if ((&acc_w[64:31]) || !(|acc_w[64:31])) begin
			sat_w = acc_w[31:0];
		end else begin
			sat_w = acc_w[64] ? sru_pkg::SAT_MIN : sru_pkg::SAT_MAX;
		end
	end

	// Next state, memory controls and multiplier operands.
	always_comb begin
		state_d      = state_q;
		x_we         = 1'b0;
		x_waddr      = IDXW'(row);
		x_wdata      = value;
		x_re         = 1'b0;
		x_raddr      = j_q;
		m_we         = 1'b0;
		m_waddr      = m_addr(IDXW'(row), IDXW'(col));
		m_wdata      = value;
		m_re         = 1'b0;
		m_raddr      = m_addr(IDXW'(row), IDXW'(col));
		mul_en       = 1'b0;
		mul_a        = alpha_q;
		mul_b        = x_rdata;
		t_en         = 1'b0;
		ph_en        = 1'b0;
		p_en         = 1'b0;
		j_clr        = 1'b0;
		j_inc        = 1'b0;
		i_init       = 1'b0;
		i_inc        = 1'b0;
		s1_load      = 1'b0;
		out_from_run = 1'b0;
		unique case (state_q)
			sru_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (op)
						sru_pkg::OP_LOAD_X: begin
							x_we    = row_ok;
							s1_load = 1'b1;
						end
						sru_pkg::OP_LOAD_M: begin
							m_we    = row_ok && col_ok;
							s1_load = 1'b1;
						end
						sru_pkg::OP_READ: begin
							m_re    = row_ok && col_ok;
							s1_load = 1'b1;
						end
						sru_pkg::OP_RUN: begin
							j_clr   = 1'b1;
							state_d = (alpha_q == 32'sd0 || n_w == '0) ?
							          sru_pkg::ST_DONE : sru_pkg::ST_COL_RD;
						end
					endcase
				end
			end
			sru_pkg::ST_COL_RD: begin
				x_re    = 1'b1;
				x_raddr = j_q;
				state_d = sru_pkg::ST_COL_MUL;
			end
			sru_pkg::ST_COL_MUL: begin
				// A zero x element leaves its whole column unchanged.
				if (x_rdata == 32'd0) begin
					j_inc   = !last_col;
					state_d = last_col ? sru_pkg::ST_DONE : sru_pkg::ST_COL_RD;
				end else begin
					mul_en  = 1'b1;
					mul_a   = alpha_q;
					mul_b   = x_rdata;
					state_d = sru_pkg::ST_COL_T;
				end
			end
			sru_pkg::ST_COL_T: begin
				t_en    = 1'b1;
				i_init  = 1'b1;
				state_d = sru_pkg::ST_ENT_RD;
			end
			sru_pkg::ST_ENT_RD: begin
				x_re    = 1'b1;
				x_raddr = i_q;
				m_re    = 1'b1;
				m_raddr = m_addr(i_q, j_q);
				state_d = sru_pkg::ST_ENT_MHI;
			end
			sru_pkg::ST_ENT_MHI: begin
				// Upper part of t, signed.
				mul_en  = 1'b1;
				mul_a   = {{8{t_q[47]}}, t_q[47:24]};
				mul_b   = x_rdata;
				state_d = sru_pkg::ST_ENT_MLO;
			end
			sru_pkg::ST_ENT_MLO: begin
				// Lower part of t, unsigned.
				ph_en   = 1'b1;
				mul_en  = 1'b1;
				mul_a   = {8'd0, t_q[23:0]};
				mul_b   = x_rdata;
				state_d = sru_pkg::ST_ENT_SUM;
			end
			sru_pkg::ST_ENT_SUM: begin
				p_en    = 1'b1;
				state_d = sru_pkg::ST_ENT_WR;
			end
			sru_pkg::ST_ENT_WR: begin
				m_we    = 1'b1;
				m_waddr = m_addr(i_q, j_q);
				m_wdata = sat_w;
				if (last_ent) begin
					j_inc   = !last_col;
					state_d = last_col ? sru_pkg::ST_DONE : sru_pkg::ST_COL_RD;
				end else begin
					i_inc   = 1'b1;
					state_d = sru_pkg::ST_ENT_RD;
				end
			end
			sru_pkg::ST_DONE: begin
				if (adv) begin
					out_from_run = 1'b1;
					state_d      = sru_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sru_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_from_s1 = valid_s1 && adv;

	// Control state: sequencer, counters, read stage, result valid and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= sru_pkg::ST_IDLE;
			j_q           <= '0;
			i_q           <= '0;
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			matrix_size_q <= sru_pkg::MATRIX_SIZE_RST;
			fill_upper_q  <= sru_pkg::FILL_UPPER_RST;
			alpha_q       <= sru_pkg::ALPHA_RST;
		end else begin
			state_q <= state_d;
			if (j_clr) begin
				j_q <= '0;
			end else if (j_inc) begin
				j_q <= j_q + IDXW'(1);
			end
			if (i_init) begin
				i_q <= fill_upper_q ? '0 : j_q;
			end else if (i_inc) begin
				i_q <= i_q + IDXW'(1);
			end
			if (s1_load) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (out_from_s1 || out_from_run) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					sru_pkg::CFG_MATRIX_SIZE: matrix_size_q <= cfg_data[4:0];
					sru_pkg::CFG_FILL_UPPER:  fill_upper_q  <= cfg_data[0];
					sru_pkg::CFG_ALPHA:       alpha_q       <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (t_en) begin
			t_q <= prod_q[63:16];
		end
		if (ph_en) begin
			ph_q <= prod_q;
		end
		if (p_en) begin
			p_q <= p_full[79:16];
		end
		if (s1_load) begin
			read_s1 <= (op == sru_pkg::OP_READ) && row_ok && col_ok;
		end
		if (out_from_s1) begin
			read_value_q <= read_s1 ? m_rdata : 32'sd0;
			run_done_q   <= 1'b0;
		end else if (out_from_run) begin
			read_value_q <= 32'sd0;
			run_done_q   <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign run_done   = run_done_q;

	// The read stage is empty whenever the sequencer owns the memory ports.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != sru_pkg::ST_IDLE) |-> !valid_s1)
	else $error("read stage busy during an update run");

	// The row and column indexes visited by the run always lie inside the active order.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sru_pkg::ST_ENT_RD) |-> (CW'(i_q) < n_w) && (CW'(j_q) < n_w))
	else $error("update run index outside the matrix order");

	// The matrix is never read and written at the same entry in one cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_we && m_re) |-> (m_waddr != m_raddr))
	else $error("matrix read and write collide on one entry");

	// A run result follows only from the final sequencer state.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_from_run |=> out_valid_q && run_done_q && (state_q == sru_pkg::ST_IDLE))
	else $error("run completion not presented as a result");

endmodule

@@ design/sru_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module sru_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read; the read data holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the symmetric rank-1 update block with its own prediction of results.
module tb;
	import sru_pkg::*;

	localparam int MAX_N = 16;

	// One expected result of a request.
	typedef struct packed {
		logic signed [31:0] rd;
		logic               done;
	} result_t;

	// One row of the directed script; fixed rows carry their result typed in.
	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  row;
		logic [3:0]  col;
		logic [31:0] val;
		logic        fixed;
		logic [31:0] rd;
		logic        done;
	} script_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = CFG_MATRIX_SIZE;
	logic [31:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         op = OP_LOAD_X;
	logic [3:0]         row = '0;
	logic [3:0]         col = '0;
	logic signed [31:0] value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] read_value;
	logic               run_done;

	// Typed-in result that travels with the request it belongs to.
	logic               req_fixed = 1'b0;
	logic signed [31:0] req_fixed_rd = '0;
	logic               req_fixed_done = 1'b0;

	// Predicted state of the block: registers, x vector and matrix.
	logic [4:0]         size_reg = MATRIX_SIZE_RST;
	logic               upper_reg = FILL_UPPER_RST;
	logic signed [31:0] alpha_reg = ALPHA_RST;
	logic signed [31:0] x_elems [MAX_N];
	logic signed [31:0] entries [MAX_N * MAX_N];

	result_t pending_results [$];
	result_t predicted;
	result_t wanted;
	int      mismatches = 0;
	logic    calm = 1'b0;

	// Directed requests after reset: extremes, ignored fields, zero alpha.
	script_row_t directed_script [13] = '{
		'{OP_RUN,    4'd9,  4'd7,  32'h1234_5678, 1'b1, 32'h0000_0000, 1'b1},
		'{OP_LOAD_X, 4'd0,  4'd15, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
		'{OP_LOAD_X, 4'd15, 4'd0,  32'h8000_0000, 1'b1, 32'h0000_0000, 1'b0},
		'{OP_LOAD_M, 4'd0,  4'd0,  32'h7FFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
		'{OP_LOAD_M, 4'd15, 4'd15, 32'h8000_0000, 1'b1, 32'h0000_0000, 1'b0},
		'{OP_LOAD_M, 4'd0,  4'd15, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
		'{OP_LOAD_M, 4'd15, 4'd0,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
		'{OP_READ,   4'd0,  4'd0,  32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0},
		'{OP_READ,   4'd15, 4'd15, 32'h0000_0000, 1'b1, 32'h8000_0000, 1'b0},
		'{OP_READ,   4'd0,  4'd15, 32'hAAAA_5555, 1'b1, 32'h0000_0000, 1'b0},
		'{OP_READ,   4'd15, 4'd0,  32'h5555_AAAA, 1'b1, 32'hFFFF_FFFF, 1'b0},
		'{OP_RUN,    4'd15, 4'd15, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b1},
		'{OP_READ,   4'd0,  4'd0,  32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 1'b0}
	};

	symmetric_rank1_update uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.row        (row),
		.col        (col),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_value (read_value),
		.run_done   (run_done)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Safety net against a hung block.
	initial begin
		#20000000;
		$display("Mismatches found");
		$finish;
	end

	// Adds alpha * x * x^T into the selected triangle, saturating each entry.
	function automatic void apply_rank1();
		int n, i, j, lo, hi;
		logic signed [63:0]  t;
		logic signed [127:0] acc;
		n = (size_reg > MAX_N) ? MAX_N : size_reg;
		if (alpha_reg != 0) begin
			for (j = 0; j < n; j++) begin
				if (x_elems[j] != 0) begin
					t = (alpha_reg * x_elems[j]) >>> 16;
					lo = upper_reg ? 0 : j;
					hi = upper_reg ? j : n - 1;
					for (i = lo; i <= hi; i++) begin
						acc = entries[i * MAX_N + j] + ((t * x_elems[i]) >>> 16);
						if (acc > SAT_MAX)
							entries[i * MAX_N + j] = SAT_MAX;
						else if (acc < SAT_MIN)
							entries[i * MAX_N + j] = SAT_MIN;
						else
							entries[i * MAX_N + j] = acc[31:0];
					end
				end
			end
		end
	endfunction

	// Updates the predicted state for one request and returns its result.
	function automatic result_t predict_request(logic [1:0] code, logic [3:0] r, logic [3:0] c,
			logic signed [31:0] v);
		result_t res;
		res = '0;
		case (code)
			OP_LOAD_X: x_elems[r] = v;
			OP_LOAD_M: entries[{r, c}] = v;
			OP_RUN: begin
				apply_rank1();
				res.done = 1'b1;
			end
			default: res.rd = entries[{r, c}];
		endcase
		return res;
	endfunction

	function automatic void apply_setting(logic [1:0] idx, logic [31:0] data);
		case (idx)
			CFG_MATRIX_SIZE: size_reg = data[4:0];
			CFG_FILL_UPPER:  upper_reg = data[0];
			CFG_ALPHA:       alpha_reg = data;
			default: ;
		endcase
	endfunction

	function automatic void note_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, msg);
	endfunction

	function automatic logic idle_now();
		return !calm && ($urandom_range(99) < 36);
	endfunction

	// Mostly indexes inside the active order, so runs show up in reads.
	function automatic logic [3:0] pick_index();
		int n;
		n = (size_reg > MAX_N) ? MAX_N : size_reg;
		if (n > 0 && $urandom_range(99) < 70)
			return 4'($urandom_range(n - 1));
		return 4'($urandom_range(15));
	endfunction

	// Q16.16 data: mostly small magnitudes, some full-range and extreme values.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(9))
			0, 1: return 32'($urandom);
			2: begin
				case ($urandom_range(4))
					0: return SAT_MAX;
					1: return SAT_MIN;
					2: return 32'sd0;
					3: return -32'sd1;
					default: return 32'sd1;
				endcase
			end
			3, 4: return 32'($urandom_range(32'hFFFF)) - 32'sh8000;
			default: return 32'($urandom_range(32'h7FFFF)) - 32'sh4_0000;
		endcase
	endfunction

	// Drives one request and holds it until it is accepted.
	task automatic send_request(logic [1:0] code, logic [3:0] r, logic [3:0] c,
			logic signed [31:0] v, logic fixed, logic signed [31:0] frd, logic fdone);
		while (idle_now()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		row <= r;
		col <= c;
		value <= v;
		req_fixed <= fixed;
		req_fixed_rd <= frd;
		req_fixed_done <= fdone;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		while (idle_now()) begin
			cfg_valid <= 1'b0;
			@(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Random request mix; the fields a request ignores still carry random bits.
	task automatic random_request();
		int pick;
		logic signed [31:0] v;
		pick = $urandom_range(99);
		if (pick < 25) begin
			v = ($urandom_range(9) == 0) ? 32'sd0 : pick_value();
			send_request(OP_LOAD_X, pick_index(), 4'($urandom), v, 1'b0, '0, 1'b0);
		end else if (pick < 50) begin
			send_request(OP_LOAD_M, pick_index(), pick_index(), pick_value(), 1'b0, '0, 1'b0);
		end else if (pick < 62) begin
			send_request(OP_RUN, 4'($urandom), 4'($urandom), 32'($urandom), 1'b0, '0, 1'b0);
		end else begin
			send_request(OP_READ, pick_index(), pick_index(), 32'($urandom), 1'b0, '0, 1'b0);
		end
	endtask

	// Waits until every request sent so far has returned its result.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] phase_alpha(int ph);
		case (ph % 6)
			0: return 32'h0001_0000;
			1: return SAT_MAX;
			2: return 32'($urandom_range(32'h3FFFF)) - 32'h2_0000;
			3: return SAT_MIN;
			4: return ALPHA_RST;
			default: return $urandom;
		endcase
	endfunction

	// Result-side stalls.
	always @(posedge clk)
		out_ready <= calm || ($urandom_range(99) >= 36);

	// Register writes update the predicted configuration.
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready)
			apply_setting(cfg_index, cfg_data);
	end

	// Accepted requests update the prediction and queue their results.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			predicted = predict_request(op, row, col, value);
			if (req_fixed) begin
				predicted.rd = req_fixed_rd;
				predicted.done = req_fixed_done;
			end
			pending_results.push_back(predicted);
		end
	end

	// Each accepted result is matched against the oldest pending one.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				note_mismatch($sformatf("unexpected result: read_value %h run_done %b",
					read_value, run_done));
			end else begin
				wanted = pending_results.pop_front();
				if (read_value !== wanted.rd)
					note_mismatch($sformatf("read_value expected %h got %h",
						wanted.rd, read_value));
				if (run_done !== wanted.done)
					note_mismatch($sformatf("run_done expected %b got %b",
						wanted.done, run_done));
			end
		end
	end

	// Stimulus: directed script, full load of x and the matrix, then random phases.
	initial begin
		int k, ph;
		logic [4:0] order_plan [12];
		order_plan = '{5'd4, 5'd0, 5'd1, 5'd31, 5'd3, 5'd6, 5'd17, 5'd2, 5'd16, 5'd5,
			5'd3, 5'd7};
		for (k = 0; k < MAX_N * MAX_N; k++)
			entries[k] = '0;
		for (k = 0; k < MAX_N; k++)
			x_elems[k] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < 13; k++)
			send_request(directed_script[k].op, directed_script[k].row, directed_script[k].col,
				directed_script[k].val, directed_script[k].fixed, directed_script[k].rd,
				directed_script[k].done);

		// Write every x element and matrix entry before any run uses them.
		for (k = 0; k < MAX_N; k++)
			send_request(OP_LOAD_X, 4'(k), 4'($urandom), pick_value(), 1'b0, '0, 1'b0);
		for (k = 0; k < MAX_N * MAX_N; k++)
			send_request(OP_LOAD_M, 4'(k / MAX_N), 4'(k % MAX_N), pick_value(), 1'b0, '0,
				1'b0);

		for (ph = 0; ph < 12; ph++) begin
			drain();
			calm = 1'b0;
			write_reg(CFG_MATRIX_SIZE, {27'd0, order_plan[ph]});
			write_reg(CFG_FILL_UPPER, {31'd0, ph[0]});
			write_reg(CFG_ALPHA, phase_alpha(ph));
			cfg_valid <= 1'b0;
			// One phase runs with no idling on either side.
			calm = (ph == 5);
			for (k = 0; k < 113; k++)
				random_request();
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
